/* src/packed_nibble_draw_engine_top_macros.svh */
`ifndef PACKED_NIBBLE_DRAW_ENGINE_TOP_MACROS_SVH
`define PACKED_NIBBLE_DRAW_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PNDE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("draw engine check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PNDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("draw engine check failed");

`endif

/* src/pnde_pkg.sv */
`timescale 1ns / 1ps

package pnde_pkg;

	localparam int FRAME_WIDTH  = 160;
	localparam int FRAME_HEIGHT = 128;
	localparam int STORE_BYTES  = (FRAME_WIDTH * FRAME_HEIGHT + 1) / 2;

	localparam int ADDR_W  = $clog2(STORE_BYTES);
	localparam int PIX_W   = ADDR_W + 1;
	localparam int XW      = $clog2(FRAME_WIDTH);
	localparam int YW      = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
	localparam int COORD_W = 13;

	localparam logic [2:0] OP_POINT   = 3'd0;
	localparam logic [2:0] OP_HLINE   = 3'd1;
	localparam logic [2:0] OP_VLINE   = 3'd2;
	localparam logic [2:0] OP_FILL    = 3'd3;
	localparam logic [2:0] OP_OUTLINE = 3'd4;
	localparam logic [2:0] OP_OUTFILL = 3'd5;
	localparam logic [2:0] OP_CLEAR   = 3'd6;
	localparam logic [2:0] OP_READ    = 3'd7;

	localparam logic [7:0] LO_MASK = 8'h0F;
	localparam logic [7:0] HI_MASK = 8'hF0;

	typedef struct packed {
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] h;
		logic [3:0]                color;
	} rect_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} walk_stat_t;

endpackage

/* src/pnde_if.sv */
`timescale 1ns / 1ps

interface pnde_cmd_if;
	logic              valid;
	logic              ready;
	logic [2:0]        operation;
	logic signed [9:0] x_pos;
	logic signed [9:0] y_pos;
	logic [8:0]        span_width;
	logic [8:0]        span_height;
	logic [3:0]        color;
	logic [3:0]        fill_color;

	modport source (
		output valid, operation, x_pos, y_pos, span_width, span_height, color, fill_color,
		input  ready
	);
	modport sink (
		input  valid, operation, x_pos, y_pos, span_width, span_height, color, fill_color,
		output ready
	);
endinterface

interface pnde_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       done_res;

	modport source (output valid, read_data, done_res, input ready);
	modport sink (input valid, read_data, done_res, output ready);
endinterface

/* src/pnde_ram.sv */
`timescale 1ns / 1ps

module pnde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/pnde_rect.sv */
`timescale 1ns / 1ps

// Clips one rectangle against the frame and walks its pixels row by row,
// doing a read-modify-write of the packed byte for each pixel.
module pnde_rect (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pnde_pkg::rect_t      rect,
	input  logic [7:0]           rdata,
	output pnde_pkg::mem_req_t   mem_req,
	output pnde_pkg::walk_stat_t stat
);

	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_BASE = 2'd1;
	localparam logic [1:0] W_RD   = 2'd2;
	localparam logic [1:0] W_WR   = 2'd3;

	localparam logic signed [pnde_pkg::COORD_W-1:0] FW_S =
		pnde_pkg::COORD_W'(pnde_pkg::FRAME_WIDTH);
	localparam logic signed [pnde_pkg::COORD_W-1:0] FH_S =
		pnde_pkg::COORD_W'(pnde_pkg::FRAME_HEIGHT);
	localparam logic signed [pnde_pkg::COORD_W-1:0] ONE_S = pnde_pkg::COORD_W'(1);

	logic [1:0] state_q;

	logic signed [pnde_pkg::COORD_W-1:0] xa_c, xb_c, ya_c, yb_c, xl_c, yl_c;
	logic empty_c;

	logic [pnde_pkg::XW-1:0]     xa_q, xl_q, x_q;
	logic [pnde_pkg::YW-1:0]     ya_q, yl_q, y_q;
	logic                        empty_q;
	logic [3:0]                  color_q;
	logic [pnde_pkg::PIX_W-1:0]  base_q, idx_c;
	logic [pnde_pkg::ADDR_W-1:0] addr_q;
	logic                        last_c;

	always_comb begin
		xa_c = (rect.x0 < 0) ? '0 : rect.x0;
		ya_c = (rect.y0 < 0) ? '0 : rect.y0;
		xb_c = rect.x0 + rect.w;
		yb_c = rect.y0 + rect.h;
		if (xb_c > FW_S) begin
			xb_c = FW_S;
		end
		if (yb_c > FH_S) begin
			yb_c = FH_S;
		end
		xl_c = xb_c - ONE_S;
		yl_c = yb_c - ONE_S;
		empty_c = (rect.w <= 0) || (rect.h <= 0) || (xa_c >= xb_c) || (ya_c >= yb_c);
	end

	assign idx_c  = base_q + pnde_pkg::PIX_W'(x_q);
	assign last_c = (x_q == xl_q) && (y_q == yl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
		end else begin
			unique case (state_q)
				W_IDLE: if (start) begin
					state_q <= W_BASE;
				end
				W_BASE: state_q <= empty_q ? W_IDLE : W_RD;
				W_RD:   state_q <= W_WR;
				W_WR:   state_q <= last_c ? W_IDLE : W_RD;
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			W_IDLE: if (start) begin
				xa_q    <= xa_c[pnde_pkg::XW-1:0];
				xl_q    <= xl_c[pnde_pkg::XW-1:0];
				ya_q    <= ya_c[pnde_pkg::YW-1:0];
				yl_q    <= yl_c[pnde_pkg::YW-1:0];
				empty_q <= empty_c;
				color_q <= rect.color;
			end
			W_BASE: begin
				base_q <= pnde_pkg::PIX_W'(ya_q * pnde_pkg::FRAME_WIDTH);
				x_q    <= xa_q;
				y_q    <= ya_q;
			end
			W_RD: addr_q <= idx_c[pnde_pkg::PIX_W-1:1];
			W_WR: begin
				if (x_q == xl_q) begin
					x_q    <= xa_q;
					y_q    <= y_q + 1'b1;
					base_q <= base_q + pnde_pkg::PIX_W'(pnde_pkg::FRAME_WIDTH);
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_req       = '0;
		mem_req.re    = (state_q == W_RD);
		mem_req.raddr = idx_c[pnde_pkg::PIX_W-1:1];
		mem_req.we    = (state_q == W_WR);
		mem_req.waddr = addr_q;
		if (x_q[0]) begin
			mem_req.wdata = (rdata & pnde_pkg::LO_MASK) | {color_q, 4'h0};
		end else begin
			mem_req.wdata = (rdata & pnde_pkg::HI_MASK) | {4'h0, color_q};
		end
	end

	assign stat.busy = (state_q != W_IDLE);
	assign stat.done = ((state_q == W_BASE) && empty_q) || ((state_q == W_WR) && last_c);

endmodule

/* src/pnde_seq.sv */
`timescale 1ns / 1ps

// Command sequencer: breaks a command into rectangles for the walker,
// and handles the clear sweep, the byte read and the result register itself.
module pnde_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	pnde_cmd_if.sink             cmd,
	pnde_res_if.source           res,
	input  pnde_pkg::walk_stat_t walk_stat,
	input  logic [7:0]           rdata,
	output logic                 walk_start,
	output pnde_pkg::rect_t      rect,
	output pnde_pkg::mem_req_t   mem_req
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SEG  = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_CLR  = 3'd3;
	localparam logic [2:0] S_RIDX = 3'd4;
	localparam logic [2:0] S_RRD  = 3'd5;
	localparam logic [2:0] S_RDAT = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	localparam logic signed [pnde_pkg::COORD_W-1:0] ONE_S = pnde_pkg::COORD_W'(1);
	localparam logic signed [pnde_pkg::COORD_W-1:0] TWO_S = pnde_pkg::COORD_W'(2);
	localparam logic signed [pnde_pkg::COORD_W-1:0] FW_S =
		pnde_pkg::COORD_W'(pnde_pkg::FRAME_WIDTH);
	localparam logic signed [pnde_pkg::COORD_W-1:0] FH_S =
		pnde_pkg::COORD_W'(pnde_pkg::FRAME_HEIGHT);
	localparam logic [pnde_pkg::ADDR_W-1:0] LAST_ADDR =
		pnde_pkg::ADDR_W'(pnde_pkg::STORE_BYTES - 1);

	logic [2:0] state_q;
	logic [2:0] seg_q, last_seg_c;

	logic [2:0]        op_q;
	logic signed [9:0] x_q, y_q;
	logic [8:0]        w_q, h_q;
	logic [3:0]        c_q, f_q;

	logic signed [pnde_pkg::COORD_W-1:0] cx, cy, cw, ch;

	logic [pnde_pkg::ADDR_W-1:0] clr_addr_q, rd_addr_q;
	logic [pnde_pkg::PIX_W-1:0]  rd_idx_c;
	logic                        rd_ok_q, in_frame_c;
	logic [7:0]                  rd_q;
	logic                        out_valid_q;
	logic [7:0]                  out_data_q;

	assign cx = pnde_pkg::COORD_W'(x_q);
	assign cy = pnde_pkg::COORD_W'(y_q);
	assign cw = signed'(pnde_pkg::COORD_W'(w_q));
	assign ch = signed'(pnde_pkg::COORD_W'(h_q));

	always_comb begin
		last_seg_c = 3'd0;
		rect = '{x0: cx, y0: cy, w: cw, h: ch, color: c_q};
		unique case (op_q)
			pnde_pkg::OP_POINT: begin
				rect.w = ONE_S;
				rect.h = ONE_S;
			end
			pnde_pkg::OP_HLINE: rect.h = ONE_S;
			pnde_pkg::OP_VLINE: rect.w = ONE_S;
			pnde_pkg::OP_FILL:  ;
			default: begin
				last_seg_c = (op_q == pnde_pkg::OP_OUTFILL) ? 3'd4 : 3'd3;
				unique case (seg_q)
					3'd0: rect.h = ONE_S;
					3'd1: begin
						rect.y0 = cy + ch;
						rect.h  = ONE_S;
					end
					3'd2: rect.w = ONE_S;
					3'd3: begin
						rect.x0 = cx + cw;
						rect.w  = ONE_S;
					end
					default: begin
						rect.x0    = cx + ONE_S;
						rect.y0    = cy + ONE_S;
						rect.w     = cw - TWO_S;
						rect.h     = ch - TWO_S;
						rect.color = f_q;
					end
				endcase
			end
		endcase
	end

	assign in_frame_c = (cx >= 0) && (cy >= 0) && (cx < FW_S) && (cy < FH_S);
	assign rd_idx_c = pnde_pkg::PIX_W'(y_q[pnde_pkg::YW-1:0] * pnde_pkg::FRAME_WIDTH)
		+ pnde_pkg::PIX_W'(x_q[pnde_pkg::XW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A finished command refills the result register as the old one leaves.
			if ((state_q == S_DONE) && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (cmd.valid) begin
					priority if (cmd.operation == pnde_pkg::OP_CLEAR) begin
						state_q <= S_CLR;
					end else if (cmd.operation == pnde_pkg::OP_READ) begin
						state_q <= S_RIDX;
					end else begin
						state_q <= S_SEG;
					end
				end
				S_SEG:  state_q <= S_WAIT;
				S_WAIT: if (walk_stat.done) begin
					state_q <= (seg_q == last_seg_c) ? S_DONE : S_SEG;
				end
				S_CLR:  if (clr_addr_q == LAST_ADDR) begin
					state_q <= S_DONE;
				end
				S_RIDX: state_q <= S_RRD;
				S_RRD:  state_q <= S_RDAT;
				S_RDAT: state_q <= S_DONE;
				S_DONE: if (!out_valid_q || res.ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (cmd.valid) begin
				op_q       <= cmd.operation;
				x_q        <= cmd.x_pos;
				y_q        <= cmd.y_pos;
				w_q        <= cmd.span_width;
				h_q        <= cmd.span_height;
				c_q        <= cmd.color;
				f_q        <= cmd.fill_color;
				seg_q      <= 3'd0;
				clr_addr_q <= '0;
				rd_q       <= 8'h00;
			end
			S_WAIT: if (walk_stat.done) begin
				seg_q <= seg_q + 3'd1;
			end
			S_CLR:  clr_addr_q <= clr_addr_q + 1'b1;
			S_RIDX: begin
				rd_ok_q   <= in_frame_c;
				rd_addr_q <= rd_idx_c[pnde_pkg::PIX_W-1:1];
			end
			S_RDAT: rd_q <= rd_ok_q ? rdata : 8'h00;
			S_DONE: if (!out_valid_q || res.ready) begin
				out_data_q <= rd_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_req       = '0;
		mem_req.re    = (state_q == S_RRD) && rd_ok_q;
		mem_req.raddr = rd_addr_q;
		mem_req.we    = (state_q == S_CLR);
		mem_req.waddr = clr_addr_q;
		mem_req.wdata = {c_q, c_q};
	end

	assign walk_start    = (state_q == S_SEG);
	assign cmd.ready     = (state_q == S_IDLE);
	assign res.valid     = out_valid_q;
	assign res.read_data = out_data_q;
	assign res.done_res  = 1'b1;

endmodule

/* src/packed_nibble_draw_engine_top.sv */
`timescale 1ns / 1ps
`include "packed_nibble_draw_engine_top_macros.svh"

// Packed 4-bit-per-pixel drawing engine. The frame is FRAME_WIDTH x FRAME_HEIGHT
// pixels stored two to a byte in one on-chip RAM; an odd x sits in the high
// nibble and an even x in the low nibble. Each command transaction draws a
// point, a span, a filled rectangle, an outline, an outline with inner fill,
// clears the frame, or reads back one packed byte, and produces exactly one
// result transaction (read_data is zero except for a read, done_res is one).
// The engine works on one command at a time and holds cmd.ready low until the
// command is finished; a finished result waits in an output register, so the
// next command is taken while the previous result is still pending. Timing is
// set by the single RAM port pair and the one rectangle walker: every clipped
// pixel costs a registered read, then a write of the merged byte, and each
// rectangle adds a clipping and setup step. Spans, points and fills are one
// rectangle, an outline is four and an outline with fill is five. A drawing
// command presents its result and raises cmd.ready again on the same edge, once
// its rectangles and pixels are done. A read passes through an index step, a RAM
// read and a data capture, and a clear writes STORE_BYTES bytes, one per cycle,
// and then finishes. The last cycle of every command is held for as long as the
// previous result has not been accepted. The frame contents are undefined after
// reset until a clear or a draw writes them.
module packed_nibble_draw_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	pnde_cmd_if.sink   cmd,
	pnde_res_if.source res
);

	pnde_pkg::walk_stat_t walk_stat;
	pnde_pkg::rect_t      rect;
	pnde_pkg::mem_req_t   seq_req, walk_req, mem_req;
	logic                 walk_start;
	logic [7:0]           rdata;

	// Command sequencer with the result register.
	pnde_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.res        (res),
		.walk_stat  (walk_stat),
		.rdata      (rdata),
		.walk_start (walk_start),
		.rect       (rect),
		.mem_req    (seq_req)
	);

	// Shared rectangle walker, used for every drawing primitive.
	pnde_rect u_rect (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (walk_start),
		.rect    (rect),
		.rdata   (rdata),
		.mem_req (walk_req),
		.stat    (walk_stat)
	);

	// The walker owns the RAM while it is busy; otherwise the sequencer does.
	assign mem_req = walk_stat.busy ? walk_req : seq_req;

	pnde_ram #(
		.WIDTH (8),
		.DEPTH (pnde_pkg::STORE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// A new command is never taken while the walker still owns the RAM.
	`PNDE_ASSERT_NOW(a_ready_walk_idle, cmd.ready, !walk_stat.busy)
	// The walker is started only when it is idle.
	`PNDE_ASSERT_NOW(a_start_idle, walk_start, !walk_stat.busy)
	// A finished rectangle leaves the walker idle in the next cycle.
	`PNDE_ASSERT_NEXT(a_done_releases, walk_stat.done, !walk_stat.busy)
	// Writes stay inside the frame store.
	`PNDE_ASSERT_NOW(a_waddr_range, mem_req.we,
		mem_req.waddr <= pnde_pkg::ADDR_W'(pnde_pkg::STORE_BYTES - 1))

endmodule

/* tb/sv/pnde_frame_tracker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the packed frame and checks
// every result transaction against the oldest outstanding command.
module pnde_frame_tracker (
	input  logic clk,
	input  logic arst_n,
	pnde_cmd_if  cmd,
	pnde_res_if  res,
	output int   fail_count,
	output int   results_outstanding
);
	import pnde_pkg::*;

	typedef struct {
		logic [7:0] read_data;
		logic       done_res;
	} draw_result_t;

	draw_result_t pending_results[$];
	logic [7:0]   frame_bytes [STORE_BYTES];

	// Odd columns live in the high nibble, even columns in the low nibble.
	function automatic void paint_pixel(int px, int py, logic [3:0] c);
		int idx;
		if (px < 0 || py < 0 || px >= FRAME_WIDTH || py >= FRAME_HEIGHT) begin
			return;
		end
		idx = (py * FRAME_WIDTH + px) / 2;
		if (px % 2 == 1) begin
			frame_bytes[idx] = (frame_bytes[idx] & LO_MASK) | {c, 4'h0};
		end else begin
			frame_bytes[idx] = (frame_bytes[idx] & HI_MASK) | {4'h0, c};
		end
	endfunction

	function automatic void paint_area(int x0, int y0, int w, int h, logic [3:0] c);
		int xa, xb, ya, yb;
		xa = x0;
		xb = x0 + w;
		ya = y0;
		yb = y0 + h;
		if (w <= 0 || h <= 0) begin
			return;
		end
		if (xa < 0) xa = 0;
		if (ya < 0) ya = 0;
		if (xb > FRAME_WIDTH) xb = FRAME_WIDTH;
		if (yb > FRAME_HEIGHT) yb = FRAME_HEIGHT;
		for (int px = xa; px < xb; px++) begin
			for (int py = ya; py < yb; py++) begin
				paint_pixel(px, py, c);
			end
		end
	endfunction

	// The right and bottom edges sit at x+w and y+h, so the far corner stays blank.
	function automatic void paint_outline(int x0, int y0, int w, int h, logic [3:0] c);
		paint_area(x0, y0, w, 1, c);
		paint_area(x0, y0 + h, w, 1, c);
		paint_area(x0, y0, 1, h, c);
		paint_area(x0 + w, y0, 1, h, c);
	endfunction

	// Applies one command to the frame copy and returns the byte it reads back.
	function automatic logic [7:0] execute_command(logic [2:0] op, int x0, int y0, int w, int h,
			logic [3:0] c, logic [3:0] f);
		logic [7:0] readback;
		readback = 8'h00;
		case (op)
			OP_POINT:   paint_pixel(x0, y0, c);
			OP_HLINE:   paint_area(x0, y0, w, 1, c);
			OP_VLINE:   paint_area(x0, y0, 1, h, c);
			OP_FILL:    paint_area(x0, y0, w, h, c);
			OP_OUTLINE: paint_outline(x0, y0, w, h, c);
			OP_OUTFILL: begin
				paint_outline(x0, y0, w, h, c);
				paint_area(x0 + 1, y0 + 1, w - 2, h - 2, f);
			end
			OP_CLEAR: begin
				foreach (frame_bytes[i]) frame_bytes[i] = {c, c};
			end
			OP_READ: begin
				if (x0 >= 0 && y0 >= 0 && x0 < FRAME_WIDTH && y0 < FRAME_HEIGHT) begin
					readback = frame_bytes[(y0 * FRAME_WIDTH + x0) / 2];
				end
			end
			default: readback = 8'h00;
		endcase
		return readback;
	endfunction

	always @(posedge clk) begin : track_channels
		draw_result_t want;
		int           xs, ys, ws, hs;
		if (arst_n) begin
			// A result always belongs to an older command, so it is retired first.
			if (res.valid && res.ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no command outstanding: read_data 0x%02h",
						res.read_data);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (res.read_data !== want.read_data) begin
						$error("read_data mismatch: expected 0x%02h, actual 0x%02h",
							want.read_data, res.read_data);
						fail_count++;
					end
					if (res.done_res !== want.done_res) begin
						$error("done_res mismatch: expected %0b, actual %0b",
							want.done_res, res.done_res);
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				xs = int'(cmd.x_pos);
				ys = int'(cmd.y_pos);
				ws = int'(cmd.span_width);
				hs = int'(cmd.span_height);
				want.read_data = execute_command(cmd.operation, xs, ys, ws, hs,
					cmd.color, cmd.fill_color);
				want.done_res  = 1'b1;
				pending_results.push_back(want);
			end
			results_outstanding = pending_results.size();
		end
	end
endmodule

/* tb/sv/packed_nibble_draw_engine_top_tb.sv */
`timescale 1ns / 1ps

module packed_nibble_draw_engine_top_tb;
	import pnde_pkg::*;

	// Roughly 500 commands in total together with the directed opening.
	localparam int RANDOM_COMMANDS = 478;
	// Most commands touch a small area at a read and a write per pixel, a clear
	// writes STORE_BYTES bytes, and a handful of frame-sized fills walk every
	// pixel of the frame. The limit leaves a wide margin over that, including
	// both sides stalling.
	localparam int LIMIT_CYCLES    = 5_000_000;
	// Every command yields its own result, so only a short settle is needed.
	localparam int SETTLE_CYCLES   = 64;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   results_outstanding;
	int   cycle_count;

	pnde_cmd_if cmd_bus ();
	pnde_res_if res_bus ();

	packed_nibble_draw_engine_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	// The tracker predicts every result and counts mismatches; this module
	// only produces stimulus and delivers the verdict.
	pnde_frame_tracker u_frame_tracker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd_bus),
		.res                 (res_bus),
		.fail_count          (fail_count),
		.results_outstanding (results_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake must not stall the run forever.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Last drawn area, used to aim reads where something was just painted.
	int anchor_x, anchor_y, anchor_w, anchor_h;
	int send_calm;

	// Drives one command transaction. All changes happen at the falling edge,
	// and the task returns right after the rising edge that accepts it, with
	// valid still high. The next call either replaces the payload at the next
	// falling edge or drops valid first for an idle gap. When drain is set the
	// sender holds off until every outstanding result has come back.
	task automatic issue_command(input logic [2:0] op, input int x0, input int y0,
			input int w, input int h, input logic [3:0] c, input logic [3:0] f,
			input bit drain);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else if ($urandom_range(0, 24) == 0) begin
			gap = 0;
			send_calm = 16;
		end else begin
			gap = $urandom_range(0, 3);
		end
		// A drain always lowers valid, so it needs a nonzero gap to avoid
		// lowering and raising valid in the same time step.
		if (drain && gap == 0) gap = 1;
		@(negedge clk);
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			while (drain && results_outstanding != 0) @(negedge clk);
			repeat (gap) @(negedge clk);
		end
		cmd_bus.operation   <= op;
		cmd_bus.x_pos       <= x0[9:0];
		cmd_bus.y_pos       <= y0[9:0];
		cmd_bus.span_width  <= w[8:0];
		cmd_bus.span_height <= h[8:0];
		cmd_bus.color       <= c;
		cmd_bus.fill_color  <= f;
		cmd_bus.valid       <= 1'b1;
		do @(posedge clk); while (!(cmd_bus.valid && cmd_bus.ready));
	endtask

	// Mostly near the frame so clipping edges are hit often; sometimes the
	// whole signed range so that every coordinate bit toggles.
	function automatic int pick_coord(int extent);
		if ($urandom_range(0, 9) < 2) begin
			return int'($urandom_range(0, 1023)) - 512;
		end
		return int'($urandom_range(0, extent + 15)) - 8;
	endfunction

	// Small sizes keep the run short; a few full-range sizes exercise the top
	// bits of the size fields and the clip against the far frame edges.
	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom_range(0, 511);
		if (r < 3) return $urandom_range(0, 40);
		return $urandom_range(0, 12);
	endfunction

	// Result side: the receiver may drop ready and stall before each result
	// transaction, with occasional stretches where it never stalls.
	initial begin : result_sink
		int gap;
		int calm;
		calm = 0;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm > 0) begin
				gap = 0;
				calm--;
			end else if ($urandom_range(0, 24) == 0) begin
				gap = 0;
				calm = 16;
			end else begin
				gap = $urandom_range(0, 3);
			end
			@(negedge clk);
			if (gap != 0) begin
				res_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
		end
	end

	initial begin : command_source
		int         r;
		int         x0, y0, w, h;
		logic [2:0] op;
		logic [3:0] c, f;

		send_calm           = 0;
		anchor_x            = 0;
		anchor_y            = 0;
		anchor_w            = 1;
		anchor_h            = 1;
		cmd_bus.valid       = 1'b0;
		cmd_bus.operation   = OP_POINT;
		cmd_bus.x_pos       = '0;
		cmd_bus.y_pos       = '0;
		cmd_bus.span_width  = '0;
		cmd_bus.span_height = '0;
		cmd_bus.color       = '0;
		cmd_bus.fill_color  = '0;
		arst_n              = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening. The frame is undefined after reset, so the very
		// first command is a clear; every read after it sees defined bytes.
		issue_command(OP_CLEAR, 0, 0, 0, 0, 4'hA, 4'h0, 1'b0);
		issue_command(OP_READ, 0, 0, 0, 0, 4'h0, 4'h0, 1'b0);
		// Even column goes to the low nibble, odd column to the high nibble.
		issue_command(OP_POINT, 0, 0, 0, 0, 4'h5, 4'h0, 1'b0);
		issue_command(OP_POINT, 1, 0, 0, 0, 4'h3, 4'h0, 1'b0);
		issue_command(OP_READ, 1, 0, 0, 0, 4'h0, 4'h0, 1'b0);
		// Last pixel of the frame.
		issue_command(OP_POINT, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 0, 0, 4'hF, 4'h0, 1'b0);
		issue_command(OP_READ, FRAME_WIDTH - 2, FRAME_HEIGHT - 1, 0, 0, 4'h0, 4'h0, 1'b0);
		// Points just outside the frame are dropped, negative ones too.
		issue_command(OP_POINT, -1, 5, 0, 0, 4'h0, 4'h0, 1'b0);
		issue_command(OP_POINT, FRAME_WIDTH, 0, 0, 0, 4'h0, 4'h0, 1'b0);
		issue_command(OP_READ, FRAME_WIDTH - 1, 0, 0, 0, 4'h0, 4'h0, 1'b0);
		// Reads outside the frame return zero, at both ends of the range.
		issue_command(OP_READ, -512, -512, 0, 0, 4'h0, 4'h0, 1'b0);
		issue_command(OP_READ, 511, 511, 511, 511, 4'hF, 4'hF, 1'b0);
		// Spans clipped on the left and top, and zero-length spans.
		issue_command(OP_HLINE, -3, 2, 10, 0, 4'h7, 4'h0, 1'b0);
		issue_command(OP_HLINE, 4, 4, 0, 0, 4'h1, 4'h0, 1'b0);
		issue_command(OP_VLINE, 1, -4, 0, 9, 4'h9, 4'h0, 1'b0);
		issue_command(OP_VLINE, 6, 6, 0, 0, 4'h2, 4'h0, 1'b0);
		issue_command(OP_READ, 0, 4, 0, 0, 4'h0, 4'h0, 1'b0);
		// Rectangle running off the bottom-right corner with maximum sizes.
		issue_command(OP_FILL, FRAME_WIDTH - 5, FRAME_HEIGHT - 3, 511, 511, 4'hC, 4'h0, 1'b0);
		issue_command(OP_READ, FRAME_WIDTH - 2, FRAME_HEIGHT - 1, 0, 0, 4'h0, 4'h0, 1'b0);
		// Outline: the far corner stays untouched.
		issue_command(OP_OUTLINE, 10, 10, 5, 4, 4'h2, 4'h0, 1'b0);
		issue_command(OP_READ, 15, 14, 0, 0, 4'h0, 4'h0, 1'b0);
		// Outline with fill, once normal and once with an empty interior.
		issue_command(OP_OUTFILL, 20, 20, 6, 5, 4'h1, 4'hE, 1'b0);
		issue_command(OP_READ, 22, 22, 0, 0, 4'h0, 4'h0, 1'b0);
		issue_command(OP_OUTFILL, 40, 40, 1, 1, 4'h3, 4'h4, 1'b0);
		issue_command(OP_FILL, -512, 3, 511, 3, 4'h6, 4'h0, 1'b0);
		issue_command(OP_CLEAR, 0, 0, 0, 0, 4'hF, 4'h0, 1'b0);

		// Random part. Reads make up about a third of the commands and mostly
		// land around the last drawn area, so draws are checked right after they
		// happen. Clears are rare because each one walks the whole store.
		for (int i = 0; i < RANDOM_COMMANDS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2) op = OP_CLEAR;
			else if (r < 34) op = OP_READ;
			else if (r < 44) op = OP_POINT;
			else if (r < 54) op = OP_HLINE;
			else if (r < 64) op = OP_VLINE;
			else if (r < 76) op = OP_FILL;
			else if (r < 88) op = OP_OUTLINE;
			else op = OP_OUTFILL;

			c = 4'($urandom_range(0, 15));
			f = 4'($urandom_range(0, 15));
			w = pick_size();
			h = pick_size();
			if (op == OP_READ) begin
				r = $urandom_range(0, 9);
				if (r < 7) begin
					x0 = anchor_x + int'($urandom_range(0, anchor_w + 2)) - 1;
					y0 = anchor_y + int'($urandom_range(0, anchor_h + 2)) - 1;
				end else if (r < 9) begin
					x0 = $urandom_range(0, FRAME_WIDTH - 1);
					y0 = $urandom_range(0, FRAME_HEIGHT - 1);
				end else begin
					x0 = pick_coord(FRAME_WIDTH);
					y0 = pick_coord(FRAME_HEIGHT);
				end
			end else begin
				x0 = pick_coord(FRAME_WIDTH);
				y0 = pick_coord(FRAME_HEIGHT);
				if (op != OP_CLEAR) begin
					anchor_x = x0;
					anchor_y = y0;
					anchor_w = (w > 16) ? 16 : w;
					anchor_h = (h > 16) ? 16 : h;
				end
			end

			// Halfway through, the sender waits for the engine to drain fully.
			issue_command(op, x0, y0, w, h, c, f, i == RANDOM_COMMANDS / 2);
		end

		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (results_outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
